// ----- src/rce_pkg.sv -----
// Shared types and constants for the range coder encoder.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package rce_pkg;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_ENCODE  = 2'd0;
    localparam logic [1:0] OP_FLUSH   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Multiply sequence phases of the shared 32x32 multiplier.
    localparam logic [2:0] MP_CL_FL = 3'd0;  // cum low  * product low
    localparam logic [2:0] MP_CH_FL = 3'd1;  // cum high * product low
    localparam logic [2:0] MP_CL_FH = 3'd2;  // cum low  * product high
    localparam logic [2:0] MP_FL_F  = 3'd3;  // product low  * freq
    localparam logic [2:0] MP_FH_F  = 3'd4;  // product high * freq
    localparam logic [2:0] MP_LAST  = 3'd5;  // final accumulate only

    localparam int SHIFT_W = 7;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_SHIFT = 5'b00100,
        S_NORM  = 5'b01000,
        S_FEND  = 5'b10000
    } state_t;

    typedef struct packed {
        logic       load_enc;
        logic       load_flush;
        logic       mul_en;
        logic [2:0] mul_phase;
        logic       shift_step;
        logic       enc_mode;
        logic       add;
        logic       norm_step;
        logic       commit;
        logic       emit_partial;
        logic       clear;
    } cmd_t;

    typedef struct packed {
        logic rem_zero;
        logic step_emits;
        logic out_free;
        logic norm_done;
    } status_t;

endpackage

// ----- src/rce_ctrl.sv -----
// Controller state machine of the range coder encoder.
// Sequences multiply, shift-out, add, normalize and flush steps of the datapath.
// Depends on rce_pkg.
module rce_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       operation,
    input  rce_pkg::status_t status,
    output rce_pkg::cmd_t    cmd
);
    import rce_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic       flush_reg, flush_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        flush_next = flush_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        OP_ENCODE:
                        begin
                            cmd.load_enc = 1'b1;
                            state_next   = S_MUL;
                            phase_next   = MP_CL_FL;
                            flush_next   = 1'b0;
                        end
                        OP_FLUSH:
                        begin
                            cmd.load_flush = 1'b1;
                            state_next     = S_SHIFT;
                            flush_next     = 1'b1;
                        end
                        OP_RESTART:
                        begin
                            cmd.clear = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = phase_reg;
                if (phase_reg == MP_LAST)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    phase_next = phase_reg + 3'd1;
                end
            end
            S_SHIFT:
            begin
                cmd.enc_mode = !flush_reg;
                if (status.rem_zero)
                begin
                    if (flush_reg)
                    begin
                        state_next = S_FEND;
                    end
                    else
                    begin
                        cmd.add    = 1'b1;
                        state_next = S_NORM;
                    end
                end
                else if (!status.step_emits || status.out_free)
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_NORM:
            begin
                if (status.norm_done)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.norm_step = 1'b1;
                end
            end
            S_FEND:
            begin
                if (status.out_free)
                begin
                    cmd.emit_partial = 1'b1;
                    cmd.clear        = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= MP_CL_FL;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            flush_reg <= flush_next;
        end
    end

endmodule

// ----- src/rce_dp.sv -----
// Datapath of the range coder encoder: coder state, shared multiplier,
// bytewise shift-out, normalize shifter and the output register.
// Depends on rce_pkg.
module rce_dp #(
    parameter int MESSAGE_WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rce_pkg::cmd_t    cmd,
    output rce_pkg::status_t status,
    input  logic [6:0]       log2_total,
    input  logic [31:0]      symbol_freq,
    input  logic [63:0]      cum_freq,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [7:0]       out_byte,
    output logic             last,
    output logic             stream_end
);
    import rce_pkg::*;

    localparam int MW = MESSAGE_WIDTH;
    localparam int CW = $clog2(MW + 1);
    localparam logic [CW-1:0] MW_C     = CW'(MW);
    localparam logic [MW-1:0] MSG_ONES = '1;
    localparam logic [63:0]   ONES64   = '1;

    // Coder state.
    logic [MW-1:0]      msg_reg;
    logic [63:0]        fp_reg;
    logic [SHIFT_W-1:0] pend_reg;
    logic [CW-1:0]      skip_reg;
    logic [2:0]         bp_reg;
    logic [7:0]         part_reg;

    // Per-item working registers.
    logic [CW-1:0]      rem_reg;
    logic [CW-1:0]      total_reg;
    logic [SHIFT_W-1:0] sh_reg;
    logic [63:0]        cum_reg;
    logic [31:0]        freq_reg;
    logic [63:0]        mul_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        prod_reg;

    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               last_reg;
    logic               end_reg;

    // Load-time values.
    logic [CW-1:0]      tot_in;
    logic [SHIFT_W-1:0] tot7;
    logic [SHIFT_W-1:0] n7;

    // Multiplier operands.
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;

    // Shift-out step.
    logic               skipping;
    logic [CW-1:0]      skip_room;
    logic [CW-1:0]      s_amt;
    logic [MW-1:0]      keep;
    logic               any_bit;
    logic [3:0]         bpn;
    logic [3:0]         t_amt;
    logic [7:0]         top8;
    logic [7:0]         window;
    logic [7:0]         lowm;
    logic [7:0]         ins;
    logic [7:0]         newpart;
    logic               full;
    logic [CW-1:0]      amt;
    logic [CW-1:0]      rem_after;
    logic               last_flag;
    logic               load_out;

    // Normalize step.
    logic [63:0]        limit;
    logic               gt1;
    logic               gt8;

    assign tot_in = (log2_total > SHIFT_W'(MW)) ? MW_C : CW'(log2_total);
    assign tot7   = SHIFT_W'(tot_in);
    assign n7     = (tot7 > pend_reg) ? (tot7 - pend_reg) : '0;

    always_comb
    begin
        case (cmd.mul_phase)
            MP_CL_FL:
            begin
                mul_a = cum_reg[31:0];
                mul_b = fp_reg[31:0];
            end
            MP_CH_FL:
            begin
                mul_a = cum_reg[63:32];
                mul_b = fp_reg[31:0];
            end
            MP_CL_FH:
            begin
                mul_a = cum_reg[31:0];
                mul_b = fp_reg[63:32];
            end
            MP_FL_F:
            begin
                mul_a = fp_reg[31:0];
                mul_b = freq_reg;
            end
            MP_FH_F:
            begin
                mul_a = fp_reg[63:32];
                mul_b = freq_reg;
            end
            default:
            begin
                mul_a = fp_reg[31:0];
                mul_b = freq_reg;
            end
        endcase
    end

    // While the first message-width bits go out they only OR into the
    // current bit; after that up to one byte's worth moves per step.
    assign skipping  = (skip_reg < MW_C);
    assign skip_room = MW_C - skip_reg;
    assign s_amt     = (rem_reg < skip_room) ? rem_reg : skip_room;
    assign keep      = MSG_ONES >> s_amt;
    assign any_bit   = |(msg_reg & ~keep);

    assign bpn     = {1'b0, bp_reg} + 4'd1;
    assign t_amt   = (rem_reg < CW'(bpn)) ? rem_reg[3:0] : bpn;
    assign top8    = msg_reg[MW-1 -: 8];
    assign window  = 8'hff >> (3'd7 - bp_reg);
    assign lowm    = window >> t_amt;
    assign ins     = (top8 >> (3'd7 - bp_reg)) & window & ~lowm;
    assign newpart = part_reg | ins;
    assign full    = (t_amt == bpn);

    assign amt       = skipping ? s_amt : CW'(t_amt);
    assign rem_after = rem_reg - amt;
    // No further byte can complete once fewer than eight bits remain.
    assign last_flag = cmd.enc_mode && (rem_after < CW'(4'd8));
    assign load_out  = (cmd.shift_step && !skipping && full) || cmd.emit_partial;

    assign limit = ONES64 >> (SHIFT_W'(64) - SHIFT_W'(total_reg));
    assign gt1   = (prod_reg > limit);
    assign gt8   = ((prod_reg >> 8) > limit);

    assign status.rem_zero   = (rem_reg == '0);
    assign status.step_emits = !skipping && (rem_reg >= CW'(bpn));
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.norm_done  = !gt1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_reg   <= '0;
            fp_reg    <= 64'd1;
            pend_reg  <= '0;
            skip_reg  <= '0;
            bp_reg    <= 3'd7;
            part_reg  <= '0;
            rem_reg   <= '0;
            total_reg <= '0;
            sh_reg    <= '0;
        end
        else if (cmd.clear)
        begin
            msg_reg  <= '0;
            fp_reg   <= 64'd1;
            pend_reg <= '0;
            skip_reg <= '0;
            bp_reg   <= 3'd7;
            part_reg <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            if (cmd.load_enc)
            begin
                rem_reg   <= CW'(n7);
                total_reg <= tot_in;
                sh_reg    <= '0;
            end
            if (cmd.load_flush)
            begin
                rem_reg <= MW_C;
            end
            if (cmd.shift_step)
            begin
                msg_reg <= msg_reg << amt;
                rem_reg <= rem_after;
                if (skipping)
                begin
                    skip_reg <= skip_reg + s_amt;
                    part_reg <= part_reg | ({7'b0, any_bit} << bp_reg);
                end
                else if (full)
                begin
                    part_reg <= '0;
                    bp_reg   <= 3'd7;
                end
                else
                begin
                    part_reg <= newpart;
                    bp_reg   <= bp_reg - t_amt[2:0];
                end
            end
            if (cmd.add)
            begin
                msg_reg <= msg_reg + acc_reg[MW-1:0];
            end
            if (cmd.norm_step)
            begin
                if (gt8)
                begin
                    sh_reg <= sh_reg + SHIFT_W'(8);
                end
                else if (gt1)
                begin
                    sh_reg <= sh_reg + SHIFT_W'(1);
                end
            end
            if (cmd.commit)
            begin
                fp_reg   <= prod_reg;
                pend_reg <= sh_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_enc)
        begin
            cum_reg  <= cum_freq;
            freq_reg <= symbol_freq;
        end
        if (cmd.mul_en)
        begin
            mul_reg <= 64'(mul_a) * 64'(mul_b);
            case (cmd.mul_phase) inside
                MP_CH_FL:
                begin
                    acc_reg <= mul_reg;
                end
                MP_CL_FH, MP_FL_F:
                begin
                    acc_reg <= acc_reg + {mul_reg[31:0], 32'b0};
                end
                MP_FH_F:
                begin
                    prod_reg <= mul_reg;
                end
                MP_LAST:
                begin
                    prod_reg <= prod_reg + {mul_reg[31:0], 32'b0};
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.norm_step)
        begin
            if (gt8)
            begin
                prod_reg <= prod_reg >> 8;
            end
            else if (gt1)
            begin
                prod_reg <= prod_reg >> 1;
            end
        end
        if (load_out)
        begin
            out_byte_reg <= cmd.emit_partial ? part_reg : newpart;
            last_reg     <= cmd.emit_partial ? 1'b1 : last_flag;
            end_reg      <= cmd.emit_partial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign last       = last_reg;
    assign stream_end = end_reg;

endmodule

// ----- src/range_coder_encoder_unit.sv -----
// Top level of the range coder encoder: controller plus datapath.
// Depends on rce_pkg, rce_ctrl and rce_dp.
//
//  channel | direction | fields                                         | handshake
//  --------+-----------+------------------------------------------------+-------------------
//  input   | in        | operation, log2_total, symbol_freq, cum_freq   | in_valid/in_ready
//  output  | out       | out_byte, last, stream_end                     | out_valid/out_ready
//
// One item is worked at a time. An encode runs the multiply phases on the shared
// 32x32 multiplier, then shift-out steps (at most one while the first message
// bits are skipped, then one per byte touched, 9 steps at most), an add and
// normalize steps of 8 or 1 bits, then the commit. A flush takes 1 to 9 shift
// steps, a step that sees the count run out and one for the final byte; a restart
// only clears the coder state. Output beats wait in a register; a stalled output
// holds the shift-out only when a byte is ready to leave. Reset is asynchronous
// and puts the coder in its initial state at once.
module range_coder_encoder_unit #(
    parameter int MESSAGE_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [6:0]  log2_total,
    input  logic [31:0] symbol_freq,
    input  logic [63:0] cum_freq,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic        stream_end
);
    import rce_pkg::*;

    cmd_t    cmd;
    status_t status;

    rce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .status    (status),
        .cmd       (cmd)
    );

    rce_dp #(
        .MESSAGE_WIDTH (MESSAGE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .log2_total  (log2_total),
        .symbol_freq (symbol_freq),
        .cum_freq    (cum_freq),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .last        (last),
        .stream_end  (stream_end)
    );

endmodule

// ----- src/rce_chk.sv -----
// Port-level checker for the range coder encoder, bound to the top level.
// Depends on rce_pkg and range_coder_encoder_unit.
module rce_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  operation,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        last,
    input logic        stream_end
);
    import rce_pkg::*;

    // A stalled output beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last)
            && $stable(stream_end))
        else $error("output beat changed while stalled");

    // The end of a stream is always the last beat of its flush.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !stream_end || last)
        else $error("stream_end without last");

    // Encode and flush occupy the block for at least the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (operation == OP_ENCODE || operation == OP_FLUSH)
            |=> !in_ready)
        else $error("block ready right after encode or flush");

    // After a restart the block is ready again in the next cycle.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == OP_RESTART |=> in_ready)
        else $error("block busy after restart");

endmodule

bind range_coder_encoder_unit rce_chk u_chk (.*);
